/* rtl/core/inverse_bwt_decoder_core_macros.svh */
// Assertion helpers for the inverse BWT decoder core.
`ifndef INVERSE_BWT_DECODER_CORE_MACROS_SVH
`define INVERSE_BWT_DECODER_CORE_MACROS_SVH

// Checked on every clock edge outside reset.
`define IBWT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define IBWT_ASSERT_ANY(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/core/ibwt_pkg.sv */
// ---------------------------------------------------------------------------
// ibwt_pkg
// Shared widths and constants of the inverse BWT decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ibwt_pkg;
   localparam int SYM_W               = 8;
   localparam int ALPHABET_SIZE       = 256;
   localparam int DEFAULT_BLOCK_DEPTH = 64;
endpackage

/* rtl/core/ibwt_sym_ram.sv */
// ---------------------------------------------------------------------------
// ibwt_sym_ram
// Per-symbol table: histogram while loading, start positions while building.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ibwt_sym_ram #(
   parameter int CNT_W = 7
) (
   input  logic                      clock,
   input  logic                      we,
   input  logic [ibwt_pkg::SYM_W-1:0] waddr,
   input  logic [CNT_W-1:0]          wdata,
   input  logic [ibwt_pkg::SYM_W-1:0] raddr,
   output logic [CNT_W-1:0]          rdata
);
   import ibwt_pkg::*;

   logic [CNT_W-1:0] mem [ALPHABET_SIZE];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

/* rtl/core/ibwt_blk_ram.sv */
// ---------------------------------------------------------------------------
// ibwt_blk_ram
// Block byte store and sorted-to-original permutation table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ibwt_blk_ram #(
   parameter int BLOCK_DEPTH = 64,
   localparam int AW = $clog2(BLOCK_DEPTH)
) (
   input  logic                       clock,
   input  logic                       st_we,
   input  logic [AW-1:0]              st_waddr,
   input  logic [ibwt_pkg::SYM_W-1:0] st_wdata,
   input  logic [AW-1:0]              st_raddr,
   output logic [ibwt_pkg::SYM_W-1:0] st_rdata,
   input  logic                       pm_we,
   input  logic [AW-1:0]              pm_waddr,
   input  logic [AW-1:0]              pm_wdata,
   input  logic [AW-1:0]              pm_raddr,
   output logic [AW-1:0]              pm_rdata
);
   import ibwt_pkg::*;

   logic [SYM_W-1:0] st_mem [BLOCK_DEPTH];
   logic [AW-1:0]    pm_mem [BLOCK_DEPTH];

   // byte store
   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[st_waddr] <= st_wdata;
      end
      st_rdata <= st_mem[st_raddr];
   end

   // permutation table
   always_ff @(posedge clock) begin
      if (pm_we) begin
         pm_mem[pm_waddr] <= pm_wdata;
      end
      pm_rdata <= pm_mem[pm_raddr];
   end
endmodule

/* rtl/core/inverse_bwt_decoder_core.sv */
// A block loads byte by byte, with a histogram read-modify-write for each
// nonzero symbol, then goes through a prefix sum over the symbol table, the
// permutation build and the walk, which emits one decoded byte at a time and
// waits for the output to be taken. A clearing pass of the symbol table
// follows reset and each block; requests wait during it, and a new block is
// not taken before the last one is decoded. Synchronous active-high reset.
// ---------------------------------------------------------------------------
// inverse_bwt_decoder_core
// Inverse Burrows-Wheeler decoder with byte 0 as the high-sorting sentinel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module inverse_bwt_decoder_core #(
   parameter int BLOCK_DEPTH = ibwt_pkg::DEFAULT_BLOCK_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [ibwt_pkg::SYM_W-1:0] req_in_byte,
   input  logic                       req_in_last,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [ibwt_pkg::SYM_W-1:0] rsp_out_byte,
   output logic                       rsp_out_last,
   output logic                       rsp_out_error
);
   import ibwt_pkg::*;

   localparam int AW = $clog2(BLOCK_DEPTH);
   localparam int CW = $clog2(BLOCK_DEPTH + 1);
   localparam int PW = SYM_W + 1;

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_LOAD = 4'd1;
   localparam logic [3:0] S_LINC = 4'd2;
   localparam logic [3:0] S_PFX  = 4'd3;
   localparam logic [3:0] S_B0   = 4'd4;
   localparam logic [3:0] S_B1   = 4'd5;
   localparam logic [3:0] S_B2   = 4'd6;
   localparam logic [3:0] S_W0   = 4'd7;
   localparam logic [3:0] S_W1   = 4'd8;
   localparam logic [3:0] S_W2   = 4'd9;
   localparam logic [3:0] S_W3   = 4'd10;
   localparam logic [3:0] S_WOUT = 4'd11;

   logic [3:0]       state_ff, state_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [1:0]       sent_ff, sent_in;
   logic             ovf_ff, ovf_in;
   logic             last_ff, last_in;
   logic [SYM_W-1:0] b_ff, b_in;
   logic [PW-1:0]    k_ff, k_in;
   logic [CW-1:0]    acc_ff, acc_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic [CW-1:0]    step_ff, step_in;
   logic [AW-1:0]    pos_ff, pos_in;
   logic             rv_ff, rv_in;
   logic [SYM_W-1:0] rb_ff, rb_in;
   logic             rl_ff, rl_in;
   logic             re_ff, re_in;

   logic             sy_we;
   logic [SYM_W-1:0] sy_waddr, sy_raddr;
   logic [CW-1:0]    sy_wdata, sy_rdata;
   logic             st_we, pm_we;
   logic [AW-1:0]    st_raddr, pm_waddr, pm_wdata, pm_raddr, pm_rdata;
   logic [SYM_W-1:0] st_rdata;

   logic             full, take, stored, err;
   logic [1:0]       sent_new;
   logic [CW-1:0]    len, cnt_new;

   ibwt_sym_ram #(.CNT_W(CW)) u_sym (
      .clock(clock), .we(sy_we), .waddr(sy_waddr), .wdata(sy_wdata),
      .raddr(sy_raddr), .rdata(sy_rdata)
   );

   ibwt_blk_ram #(.BLOCK_DEPTH(BLOCK_DEPTH)) u_blk (
      .clock(clock),
      .st_we(st_we), .st_waddr(cnt_ff[AW-1:0]), .st_wdata(req_in_byte),
      .st_raddr(st_raddr), .st_rdata(st_rdata),
      .pm_we(pm_we), .pm_waddr(pm_waddr), .pm_wdata(pm_wdata),
      .pm_raddr(pm_raddr), .pm_rdata(pm_rdata)
   );

   assign req_ready     = (state_ff == S_LOAD);
   assign rsp_valid     = rv_ff;
   assign rsp_out_byte  = rb_ff;
   assign rsp_out_last  = rl_ff;
   assign rsp_out_error = re_ff;

   // load-side status of the incoming request
   assign take     = req_valid && req_ready;
   assign full     = (cnt_ff == CW'(BLOCK_DEPTH));
   assign stored   = !full;
   assign len      = cnt_ff - CW'(1);
   assign cnt_new  = cnt_ff + CW'(1);
   assign sent_new = (stored && req_in_byte == '0 && sent_ff != 2'd2) ?
                     sent_ff + 2'd1 : sent_ff;
   assign err      = ovf_ff || full || (sent_new != 2'd1);
   assign st_we    = take && stored;

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      sent_in  = sent_ff;
      ovf_in   = ovf_ff;
      last_in  = last_ff;
      b_in     = b_ff;
      k_in     = k_ff;
      acc_in   = acc_ff;
      idx_in   = idx_ff;
      step_in  = step_ff;
      pos_in   = pos_ff;
      rv_in    = rv_ff;
      rb_in    = rb_ff;
      rl_in    = rl_ff;
      re_in    = re_ff;
      sy_we    = 1'b0;
      sy_waddr = b_ff;
      sy_wdata = sy_rdata + CW'(1);
      sy_raddr = req_in_byte;
      pm_we    = 1'b0;
      pm_waddr = sy_rdata[AW-1:0];
      pm_wdata = idx_ff[AW-1:0];
      pm_raddr = pos_ff;
      st_raddr = idx_ff[AW-1:0];
      unique case (state_ff)
         S_CLR: begin
            sy_we    = 1'b1;
            sy_waddr = k_ff[SYM_W-1:0];
            sy_wdata = '0;
            cnt_in   = '0;
            sent_in  = '0;
            ovf_in   = 1'b0;
            k_in     = k_ff + PW'(1);
            if (k_ff[SYM_W-1:0] == '1) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (take) begin
               b_in    = req_in_byte;
               last_in = req_in_last;
               sent_in = sent_new;
               ovf_in  = ovf_ff || full;
               if (stored) begin
                  cnt_in = cnt_new;
               end
               k_in   = PW'(1);
               acc_in = '0;
               idx_in = '0;
               step_in = '0;
               if (req_in_last && err) begin
                  rv_in    = 1'b1;
                  rb_in    = '0;
                  rl_in    = 1'b1;
                  re_in    = 1'b1;
                  state_in = S_WOUT;
               end else if (stored && req_in_byte != '0) begin
                  state_in = S_LINC;
               end else if (req_in_last) begin
                  // a sentinel-only block decodes to nothing
                  state_in = (cnt_new == CW'(1)) ? S_CLR : S_PFX;
                  k_in     = (cnt_new == CW'(1)) ? '0 : PW'(1);
               end
            end
         end
         S_LINC: begin
            sy_we    = 1'b1;
            state_in = last_ff ? S_PFX : S_LOAD;
         end
         S_PFX: begin
            // exclusive prefix sum over symbols 1..255, written back in place
            sy_raddr = k_ff[SYM_W-1:0];
            k_in     = k_ff + PW'(1);
            if (k_ff != PW'(1)) begin
               sy_we    = 1'b1;
               sy_waddr = SYM_W'(k_ff - PW'(1));
               sy_wdata = acc_ff;
               acc_in   = acc_ff + sy_rdata;
            end
            if (k_ff == PW'(ALPHABET_SIZE)) begin
               state_in = S_B0;
            end
         end
         S_B0: begin
            state_in = S_B1;
         end
         S_B1: begin
            b_in     = st_rdata;
            sy_raddr = st_rdata;
            if (st_rdata == '0) begin
               pm_we    = 1'b1;
               pm_waddr = len[AW-1:0];
               idx_in   = idx_ff + CW'(1);
               state_in = (idx_ff + CW'(1) == cnt_ff) ? S_W0 : S_B0;
            end else begin
               state_in = S_B2;
            end
         end
         S_B2: begin
            pm_we    = 1'b1;
            sy_we    = 1'b1;
            idx_in   = idx_ff + CW'(1);
            state_in = (idx_ff + CW'(1) == cnt_ff) ? S_W0 : S_B0;
         end
         S_W0: begin
            pm_raddr = len[AW-1:0];
            state_in = S_W1;
         end
         S_W1: begin
            pm_raddr = pm_rdata;
            state_in = S_W2;
         end
         S_W2: begin
            pos_in   = pm_rdata;
            st_raddr = pm_rdata;
            state_in = S_W3;
         end
         S_W3: begin
            rv_in    = 1'b1;
            rb_in    = st_rdata;
            rl_in    = (step_ff + CW'(1) == len);
            re_in    = 1'b0;
            state_in = S_WOUT;
         end
         S_WOUT: begin
            if (rsp_ready) begin
               rv_in   = 1'b0;
               step_in = step_ff + CW'(1);
               if (rl_ff) begin
                  k_in     = '0;
                  state_in = S_CLR;
               end else begin
                  state_in = S_W2;
               end
            end
         end
         default: begin
            state_in = S_CLR;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         k_ff     <= '0;
         cnt_ff   <= '0;
         sent_ff  <= '0;
         ovf_ff   <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         cnt_ff   <= cnt_in;
         sent_ff  <= sent_in;
         ovf_ff   <= ovf_in;
         rv_ff    <= rv_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      last_ff <= last_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      idx_ff  <= idx_in;
      step_ff <= step_in;
      pos_ff  <= pos_in;
      rb_ff   <= rb_in;
      rl_ff   <= rl_in;
      re_ff   <= re_in;
   end
endmodule

/* rtl/core/ibwt_checker.sv */
// ---------------------------------------------------------------------------
// ibwt_checker
// Port-level checks of the inverse BWT decoder core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "inverse_bwt_decoder_core_macros.svh"

module ibwt_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic [ibwt_pkg::SYM_W-1:0] req_in_byte,
   input logic                       req_in_last,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [ibwt_pkg::SYM_W-1:0] rsp_out_byte,
   input logic                       rsp_out_last,
   input logic                       rsp_out_error
);
   // nothing offered or taken right after reset
   `IBWT_ASSERT_ANY(a_reset_quiet, reset |=> (!rsp_valid && !req_ready), "busy after reset")

   // a waiting request holds its payload
   `IBWT_ASSERT(a_req_hold, (req_valid && !req_ready) |=> (req_valid && $stable(req_in_byte) && $stable(req_in_last)), "request dropped or changed while waiting")

   // a waiting result holds its payload
   `IBWT_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_byte) && $stable(rsp_out_last) && $stable(rsp_out_error)), "result dropped or changed while waiting")

   // error result is a single zero byte that closes the block
   `IBWT_ASSERT(a_err_form, (rsp_valid && rsp_out_error) |-> (rsp_out_last && rsp_out_byte == '0), "malformed error result")

   // requests are not taken while a result is pending
   `IBWT_ASSERT(a_one_side, !(rsp_valid && req_ready), "request side open during output")
endmodule

bind inverse_bwt_decoder_core ibwt_checker u_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_ready(req_ready),
   .req_in_byte(req_in_byte), .req_in_last(req_in_last),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_out_byte(rsp_out_byte), .rsp_out_last(rsp_out_last),
   .rsp_out_error(rsp_out_error)
);

/* tb/tb.sv */
// ---------------------------------------------------------------------------
// Inverse BWT decoder testbench
// Feeds transformed blocks (valid, malformed and overflowing) with random
// idling on both sides, predicts the decoded stream and checks each result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import ibwt_pkg::*;

   localparam int DEPTH     = DEFAULT_BLOCK_DEPTH;
   localparam int MAX_CYCLE = 3000000;
   localparam int DRAIN     = 600;

   typedef struct packed {
      logic [SYM_W-1:0] sym;
      logic             last;
   } request_type;

   typedef struct packed {
      logic [SYM_W-1:0] sym;
      logic             last;
      logic             error;
   } decoded_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic [SYM_W-1:0] req_in_byte;
   logic             req_in_last;
   logic             rsp_valid;
   logic             rsp_ready;
   logic [SYM_W-1:0] rsp_out_byte;
   logic             rsp_out_last;
   logic             rsp_out_error;

   request_type pending_q[$];
   decoded_type decoded_q[$];
   int       fail_count;
   int       cycle_count;
   int       sent_count;
   int       result_count;
   int       block_count;
   int       error_blocks;
   bit       no_idle;

   // predictor state
   logic [SYM_W-1:0] blk_store[DEPTH];
   int               sym_hist[ALPHABET_SIZE];
   int               blk_len;
   int               zero_seen;
   bit               blk_overflow;

   inverse_bwt_decoder_core DUT (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report(input string what);
      fail_count++;
      $display("ERROR @%0d: %s", cycle_count, what);
   endtask

   // accepted request -> expected decoded bytes
   task automatic predict_decode(input request_type r);
      int start[ALPHABET_SIZE];
      int perm[DEPTH];
      int nz;
      int acc;
      int dst;
      int pos;
      if (blk_len < DEPTH) begin
         blk_store[blk_len] = r.sym;
         blk_len++;
         if (r.sym == 0) begin
            if (zero_seen < 2) zero_seen++;
         end else begin
            sym_hist[r.sym]++;
         end
      end else begin
         blk_overflow = 1'b1;
      end
      if (!r.last) return;
      block_count++;
      if (blk_overflow || zero_seen != 1) begin
         error_blocks++;
         decoded_q.push_back('{sym: '0, last: 1'b1, error: 1'b1});
      end else begin
         nz = blk_len - 1;
         acc = 0;
         for (int s = 1; s < ALPHABET_SIZE; s++) begin
            start[s] = acc;
            acc += sym_hist[s];
         end
         for (int i = 0; i < blk_len; i++) begin
            if (blk_store[i] == 0) dst = nz;
            else dst = start[blk_store[i]]++;
            perm[dst] = i;
         end
         pos = perm[nz];
         for (int i = 0; i < nz; i++) begin
            pos = perm[pos];
            decoded_q.push_back('{sym: blk_store[pos], last: (i + 1 == nz), error: 1'b0});
         end
      end
      foreach (sym_hist[s]) sym_hist[s] = 0;
      blk_len = 0;
      zero_seen = 0;
      blk_overflow = 1'b0;
   endtask

   function automatic bit idle_now();
      return !no_idle && ($urandom_range(99) < 29);
   endfunction

   // random payload byte, never the sentinel
   function automatic logic [SYM_W-1:0] any_symbol();
      return SYM_W'($urandom_range(255, 1));
   endfunction

   // a block with nsym nonzero bytes and one sentinel at a random slot
   task automatic queue_good_block(input int nsym);
      int zpos;
      zpos = $urandom_range(nsym);
      for (int i = 0; i <= nsym; i++)
         pending_q.push_back('{sym: (i == zpos) ? SYM_W'(0) : any_symbol(),
                               last: (i == nsym)});
   endtask

   task automatic queue_raw(input int n, input int zeros);
      for (int i = 0; i < n; i++)
         pending_q.push_back('{sym: (i < zeros) ? SYM_W'(0) : any_symbol(),
                               last: (i == n - 1)});
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_q.size() != 0 && !idle_now()) begin
            req_valid   <= 1'b1;
            req_in_byte <= pending_q[0].sym;
            req_in_last <= pending_q[0].last;
            void'(pending_q.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor and predictor feed
   always @(posedge clock) begin
      decoded_type want;
      cycle_count++;
      if (!reset) begin
         if (req_valid && req_ready) begin
            sent_count++;
            predict_decode('{sym: req_in_byte, last: req_in_last});
         end
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (decoded_q.size() == 0) begin
               report($sformatf("unexpected result %h", rsp_out_byte));
            end else begin
               want = decoded_q.pop_front();
               if (rsp_out_byte !== want.sym)
                  report($sformatf("byte %h, want %h", rsp_out_byte, want.sym));
               if (rsp_out_last !== want.last)
                  report($sformatf("last %b, want %b", rsp_out_last, want.last));
               if (rsp_out_error !== want.error)
                  report($sformatf("error %b, want %b", rsp_out_error, want.error));
            end
         end
         rsp_ready <= !idle_now();
      end
      if (cycle_count > MAX_CYCLE) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("inverse_bwt_decoder_core: mismatch");
         $finish;
      end
   end

   initial begin
      int nsym;
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_byte = '0;
      req_in_last = 1'b0;
      rsp_ready = 1'b0;
      no_idle = 1'b0;
      blk_len = 0;
      zero_seen = 0;
      blk_overflow = 1'b0;
      foreach (sym_hist[s]) sym_hist[s] = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: sentinel only, one symbol, extremes, repeats, bad blocks
      queue_raw(1, 1);
      pending_q.push_back('{sym: 8'hff, last: 1'b0});
      pending_q.push_back('{sym: 8'h00, last: 1'b1});
      pending_q.push_back('{sym: 8'h01, last: 1'b0});
      pending_q.push_back('{sym: 8'h00, last: 1'b0});
      pending_q.push_back('{sym: 8'h01, last: 1'b0});
      pending_q.push_back('{sym: 8'hff, last: 1'b1});
      queue_raw(3, 0);
      queue_raw(4, 2);
      queue_raw(3, 3);
      while (pending_q.size() != 0 || decoded_q.size() != 0) @(posedge clock);

      // full store and overflow
      queue_good_block(DEPTH - 1);
      queue_good_block(DEPTH);
      while (pending_q.size() != 0 || decoded_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      // random blocks, mostly well formed and short
      while (sent_count < 250) begin
         no_idle = (sent_count > 120 && sent_count < 170);
         case ($urandom_range(9))
            0: queue_raw($urandom_range(8, 1), $urandom_range(3) == 0 ? 0 : 2);
            1: queue_good_block($urandom_range(DEPTH - 1));
            default: queue_good_block($urandom_range(10));
         endcase
         while (pending_q.size() != 0) @(posedge clock);
      end
      no_idle = 1'b0;

      while (decoded_q.size() != 0 || req_valid) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      $display("covered %0d requests in %0d blocks (%0d bad), %0d results checked",
               sent_count, block_count, error_blocks, result_count);
      if (fail_count == 0 && decoded_q.size() == 0)
         $display("inverse_bwt_decoder_core: match");
      else
         $display("inverse_bwt_decoder_core: mismatch");
      $finish;
   end
endmodule

/* files.f */
+incdir+rtl/core
rtl/core/ibwt_pkg.sv
rtl/core/ibwt_sym_ram.sv
rtl/core/ibwt_blk_ram.sv
rtl/core/inverse_bwt_decoder_core.sv
rtl/core/ibwt_checker.sv
tb/tb.sv
